FILE: design/asah_pkg.sv
package asah_pkg;

   // command codes carried in req_tuser
   typedef enum logic [1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   // configuration register indexes
   localparam logic [2:0] CSR_UPPER_THR   = 3'd0;
   localparam logic [2:0] CSR_LOWER_THR   = 3'd1;
   localparam logic [2:0] CSR_UPPER_OFF   = 3'd2;
   localparam logic [2:0] CSR_LOWER_OFF   = 3'd3;
   localparam logic [2:0] CSR_SAMPLES     = 3'd4;
   localparam logic [2:0] CSR_AVG_SHIFT   = 3'd5;

   // configuration reset values
   localparam logic [9:0] UPPER_THR_RST   = 10'd1008;
   localparam logic [9:0] LOWER_THR_RST   = 10'd15;
   localparam logic [9:0] UPPER_OFF_RST   = 10'd15;
   localparam logic [9:0] LOWER_OFF_RST   = 10'd15;
   localparam logic [4:0] SAMPLES_RST     = 5'd4;
   localparam logic [2:0] AVG_SHIFT_RST   = 3'd2;

   // saturation limits
   localparam logic [13:0] SUM_MAX        = 14'd16383;
   localparam logic [9:0]  VALUE_MAX      = 10'd1023;

   // one entry of the channel memory
   typedef struct packed {
      logic        low_act;
      logic        high_act;
      logic [13:0] sum;
   } word_type;

endpackage

FILE: design/adc_scan_accumulate_hysteresis_top.sv
// throughput: one item per cycle unless rsp_tready holds the output back, set
// by the read-modify-write of the channel memory (read at accept, write back
// as the item leaves stage 1)
// reset: synchronous active high; scan position, pass count, config registers and
// per-channel valid bits clear at once, so no memory clearing pass is needed
module adc_scan_accumulate_hysteresis_top #(
   parameter int CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample[9:0], read_channel[13:10], zero fill
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // value[9:0], next_channel[13:10], data_ready[14]
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration registers
   logic [9:0] upper_thr_ff, lower_thr_ff, upper_off_ff, lower_off_ff;
   logic [4:0] samples_ff;
   logic [2:0] avg_shift_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_thr_ff <= asah_pkg::UPPER_THR_RST;
         lower_thr_ff <= asah_pkg::LOWER_THR_RST;
         upper_off_ff <= asah_pkg::UPPER_OFF_RST;
         lower_off_ff <= asah_pkg::LOWER_OFF_RST;
         samples_ff   <= asah_pkg::SAMPLES_RST;
         avg_shift_ff <= asah_pkg::AVG_SHIFT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            asah_pkg::CSR_UPPER_THR: upper_thr_ff <= csr_data;
            asah_pkg::CSR_LOWER_THR: lower_thr_ff <= csr_data;
            asah_pkg::CSR_UPPER_OFF: upper_off_ff <= csr_data;
            asah_pkg::CSR_LOWER_OFF: lower_off_ff <= csr_data;
            asah_pkg::CSR_SAMPLES:   samples_ff   <= csr_data[4:0];
            asah_pkg::CSR_AVG_SHIFT: avg_shift_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // input field unpacking
   logic [9:0]      req_sample;
   logic [3:0]      req_rch;
   logic [CH_W+3:0] rch_ext;
   logic [CH_W-1:0] rch_addr;
   logic            rch_in_range;

   assign req_sample   = req_tdata[9:0];
   assign req_rch      = req_tdata[13:10];
   assign rch_ext      = {{CH_W{1'b0}}, req_rch};
   assign rch_addr     = rch_ext[CH_W-1:0];
   assign rch_in_range = (int'(req_rch) < CHANNELS);

   // pipeline handshake
   logic s1_valid_ff, s1_adv, req_acc, rsp_valid_ff;

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   // scan position and pass counter
   logic [CH_W-1:0] scan_ff, scan_in;
   logic [7:0]      pass_ff, pass_in;

   always_comb begin
      scan_in = scan_ff;
      pass_in = pass_ff;
      if (req_tuser == asah_pkg::CMD_SAMPLE) begin
         if (scan_ff == CH_W'(CHANNELS - 1)) begin
            scan_in = '0;
            pass_in = pass_ff + 8'd1;
         end else begin
            scan_in = scan_ff + CH_W'(1);
         end
      end else if (req_tuser == asah_pkg::CMD_RESTART) begin
         scan_in = '0;
         pass_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         pass_ff <= '0;
      end else if (req_acc) begin
         scan_ff <= scan_in;
         pass_ff <= pass_in;
      end
   end

   logic [CH_W+3:0] scan_ext;
   logic [CH_W-1:0] rd_addr;

   assign scan_ext = {4'b0, scan_in};
   assign rd_addr  = (req_tuser == asah_pkg::CMD_SAMPLE) ? scan_ff : rch_addr;

   // channel memory with per-entry valid bits
   asah_pkg::word_type sum_mem [CHANNELS];
   logic [CHANNELS-1:0] entry_valid_ff;
   asah_pkg::word_type  rd_word_ff;
   logic                rd_valid_ff;

   logic               mem_we;
   logic [CH_W-1:0]    wr_addr;
   asah_pkg::word_type wr_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[wr_addr] <= wr_word;
      end
      if (req_acc) begin
         rd_word_ff  <= sum_mem[rd_addr];
         rd_valid_ff <= entry_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (mem_we) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // forwarding for a write landing on the entry read at the same edge
   logic               fwd_hit_ff;
   asah_pkg::word_type fwd_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (req_acc) begin
         fwd_hit_ff <= mem_we && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         fwd_word_ff <= wr_word;
      end
   end

   // stage 1 item registers
   logic [1:0]      s1_cmd_ff;
   logic [9:0]      s1_sample_ff;
   logic [CH_W-1:0] s1_addr_ff;
   logic            s1_in_range_ff;
   logic [3:0]      s1_next_ch_ff;
   logic            s1_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff      <= req_tuser;
         s1_sample_ff   <= req_sample;
         s1_addr_ff     <= rd_addr;
         s1_in_range_ff <= rch_in_range;
         s1_next_ch_ff  <= scan_ext[3:0];
         s1_ready_ff    <= (pass_in == {3'b0, samples_ff});
      end
   end

   // current entry contents
   asah_pkg::word_type cur_word;

   always_comb begin
      priority if (fwd_hit_ff) begin
         cur_word = fwd_word_ff;
      end else if (rd_valid_ff) begin
         cur_word = rd_word_ff;
      end else begin
         cur_word = '0;
      end
   end

   // accumulate with saturation
   logic [14:0] acc_sum;
   logic [13:0] acc_sat;

   assign acc_sum = {1'b0, cur_word.sum} + {5'b0, s1_sample_ff};
   assign acc_sat = acc_sum[14] ? asah_pkg::SUM_MAX : acc_sum[13:0];

   // averaged value and hysteresis comparisons
   logic [13:0] avg;
   logic [10:0] low_lim;
   logic [9:0]  up_lim;
   logic        band_ok, above, below_up, below_ls, below_lt;
   logic [14:0] add_full;
   logic [9:0]  add_res, sub_res, clip_res;
   logic [13:0] sub_full;

   assign avg      = cur_word.sum >> avg_shift_ff;
   assign band_ok  = (upper_thr_ff >= upper_off_ff);
   assign up_lim   = upper_thr_ff - upper_off_ff;
   assign low_lim  = {1'b0, lower_thr_ff} + {1'b0, lower_off_ff};
   assign above    = (avg > {4'b0, upper_thr_ff});
   assign below_up = band_ok && (avg < {4'b0, up_lim});
   assign below_ls = (avg < {3'b0, low_lim});
   assign below_lt = (avg < {4'b0, lower_thr_ff});

   assign add_full = {1'b0, avg} + {5'b0, upper_off_ff};
   assign add_res  = (add_full > {5'b0, asah_pkg::VALUE_MAX}) ? asah_pkg::VALUE_MAX
                                                               : add_full[9:0];
   assign sub_full = avg - {4'b0, lower_off_ff};
   assign sub_res  = (avg > {4'b0, lower_off_ff}) ? sub_full[9:0] : 10'd0;
   assign clip_res = (avg > {4'b0, asah_pkg::VALUE_MAX}) ? asah_pkg::VALUE_MAX : avg[9:0];

   // hysteresis result and sticky flags
   logic [9:0] hyst_val;
   logic       hyst_hi, hyst_lo;

   always_comb begin
      hyst_hi = cur_word.high_act;
      hyst_lo = cur_word.low_act;
      priority if (above) begin
         hyst_hi  = 1'b1;
         hyst_lo  = 1'b0;
         hyst_val = add_res;
      end else if (below_up) begin
         hyst_hi = 1'b0;
         priority if (below_ls && below_lt) begin
            hyst_lo  = 1'b1;
            hyst_val = sub_res;
         end else if (below_ls) begin
            hyst_val = cur_word.low_act ? sub_res : clip_res;
         end else begin
            hyst_lo  = 1'b0;
            hyst_val = clip_res;
         end
      end else begin
         hyst_val = cur_word.high_act ? add_res : clip_res;
      end
   end

   // write back and result value
   logic [9:0] s1_value;
   logic       s1_leave;

   assign s1_leave = s1_valid_ff && s1_adv;
   assign wr_addr  = s1_addr_ff;

   always_comb begin
      mem_we   = 1'b0;
      wr_word  = cur_word;
      s1_value = '0;
      if (s1_cmd_ff == asah_pkg::CMD_SAMPLE) begin
         mem_we       = s1_leave;
         wr_word.sum  = acc_sat;
      end else if (s1_cmd_ff == asah_pkg::CMD_READ && s1_in_range_ff) begin
         mem_we           = s1_leave;
         wr_word.sum      = '0;
         wr_word.high_act = hyst_hi;
         wr_word.low_act  = hyst_lo;
         s1_value         = hyst_val;
      end
   end

   // output register
   logic [9:0] rsp_value_ff;
   logic [3:0] rsp_next_ch_ff;
   logic       rsp_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         rsp_value_ff   <= s1_value;
         rsp_next_ch_ff <= s1_next_ch_ff;
         rsp_ready_ff   <= s1_ready_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ready_ff, rsp_next_ch_ff, rsp_value_ff};

`ifndef NO_ASSERTIONS
   // an accepted item always occupies stage 1 next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted item did not reach stage 1");

   // memory is written only by an item leaving stage 1
   a_write_on_leave: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (s1_valid_ff && s1_adv))
      else $error("memory write without a departing item");

   // only a read command yields a nonzero value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_leave && s1_cmd_ff != asah_pkg::CMD_READ) |=> (rsp_value_ff == 10'd0))
      else $error("nonzero value for a non-read item");

   // scan position never leaves the channel range
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      int'(scan_ff) < CHANNELS)
      else $error("scan position out of range");
`endif

endmodule
